// ----- design/tcw_pkg.sv -----
// tcw_pkg: shared constants and types for the text console writer
// screen geometry, command and character codes, controller states
// no dependencies

package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int COPY_N    = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int COL_SUM_W = COL_W + 1;
    localparam int TAB_W     = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

    localparam logic [7:0]  RESET_ATTR = 8'h07;
    localparam logic [15:0] RESET_CELL = {RESET_ATTR, 8'h00};

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } state_t;

endpackage

// ----- design/text_console_writer_top.sv -----
// text_console_writer_top: text console engine with a cell store and a cursor
// depends on tcw_pkg

// Text console: an 80x25 store of char/attribute cells in one synchronous RAM
// (one write and one read port, registered read data) plus a write cursor.
// After reset the block sweeps the store to char 0 / attribute 7, one cell a
// cycle, before it takes its first item; configuration writes are taken at
// any time. A put that does not scroll and an unused command load their
// result straight into the staging register, and a read first waits in a
// state for the registered RAM read data. A put that scrolls copies rows up
// through the RAM read port one cell a cycle and then blanks the bottom row.
// A clear writes every cell once. A new item is accepted only while the
// controller is idle and the staging register is empty. The result goes
// through a staging register and an output register, so a finished item may
// wait for out_ready while the next item is accepted.

module text_console_writer_top
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] text_attr,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] char_code,
    input  logic [4:0] cell_row,
    input  logic [6:0] cell_col,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cell_char,
    output logic [7:0] cell_attr,
    output logic [4:0] cursor_row,
    output logic [6:0] cursor_col
);

    tcw_pkg::state_t state_reg, state_next;

    logic [7:0]                  attr_reg;
    logic [tcw_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [tcw_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tcw_pkg::TAB_W-1:0]   phase_reg, phase_next;
    logic [tcw_pkg::ADDR_W-1:0]  cnt_reg, cnt_next;
    logic                        cp_valid_reg, cp_valid_next;
    logic [tcw_pkg::ADDR_W-1:0]  cp_dst_reg, cp_dst_next;
    logic                        rd_ok_reg, rd_ok_next;

    logic                        res_valid_reg, res_valid_next;
    logic [7:0]                  res_char_reg, res_char_next;
    logic [7:0]                  res_attr_reg, res_attr_next;
    logic                        res_move;
    logic                        res_load;

    logic                        out_valid_reg;
    logic [7:0]                  out_char_reg;
    logic [7:0]                  out_attr_reg;
    logic [tcw_pkg::ROW_W-1:0]   out_row_reg;
    logic [tcw_pkg::COL_W-1:0]   out_col_reg;

    logic [15:0]                 mem [tcw_pkg::CELLS];
    logic                        ram_we;
    logic [tcw_pkg::ADDR_W-1:0]  ram_waddr;
    logic [15:0]                 ram_wdata;
    logic                        ram_re;
    logic [tcw_pkg::ADDR_W-1:0]  ram_raddr;
    logic [15:0]                 rdata_reg;

    logic                        in_fire;
    logic [tcw_pkg::ADDR_W-1:0]  cur_addr;
    logic [tcw_pkg::ADDR_W-1:0]  rd_addr;
    logic                        rd_in_range;
    logic [tcw_pkg::COL_SUM_W-1:0] col_sum;
    logic                        row_inc;
    logic [15:0]                 blank_cell;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == tcw_pkg::ST_IDLE) && !res_valid_reg;
    assign in_fire    = in_valid && in_ready;
    assign blank_cell = {attr_reg, 8'h00};

    assign cur_addr = tcw_pkg::ADDR_W'(row_reg) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                    + tcw_pkg::ADDR_W'(col_reg);
    assign rd_addr  = tcw_pkg::ADDR_W'(cell_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                    + tcw_pkg::ADDR_W'(cell_col);
    assign rd_in_range = (cell_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
                      && (cell_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));

    assign res_move = res_valid_reg && (!out_valid_reg || out_ready);

    // cell store
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            rdata_reg <= mem[ram_raddr];
        end
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tcw_pkg::RESET_ATTR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            attr_reg <= text_attr;
        end
    end

    // next state, cursor update and store accesses
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        cp_valid_next  = 1'b0;
        cp_dst_next    = cp_dst_reg;
        rd_ok_next     = rd_ok_reg;
        res_load       = 1'b0;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = blank_cell;
        ram_re         = 1'b0;
        ram_raddr      = rd_addr;
        col_sum        = tcw_pkg::COL_SUM_W'(col_reg);
        row_inc        = 1'b0;

        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = tcw_pkg::RESET_CELL;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_char_next = 8'h00;
                    res_attr_next = 8'h00;
                    case (tcw_pkg::cmd_t'(command))
                        tcw_pkg::CMD_PUT:
                        begin
                            case (char_code)
                                tcw_pkg::CH_CR:
                                begin
                                    col_sum    = '0;
                                    phase_next = '0;
                                end
                                tcw_pkg::CH_LF:
                                begin
                                    col_sum    = '0;
                                    phase_next = '0;
                                    row_inc    = 1'b1;
                                end
                                tcw_pkg::CH_TAB:
                                begin
                                    col_sum = tcw_pkg::COL_SUM_W'(col_reg)
                                            + tcw_pkg::COL_SUM_W'(tcw_pkg::TAB_WIDTH)
                                            - tcw_pkg::COL_SUM_W'(phase_reg);
                                    phase_next = '0;
                                end
                                default:
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = cur_addr;
                                    ram_wdata = {attr_reg, char_code};
                                    col_sum   = tcw_pkg::COL_SUM_W'(col_reg) + 1'b1;
                                    if (phase_reg == tcw_pkg::TAB_W'(tcw_pkg::TAB_WIDTH - 1))
                                    begin
                                        phase_next = '0;
                                    end
                                    else
                                    begin
                                        phase_next = phase_reg + 1'b1;
                                    end
                                end
                            endcase

                            // wrap past the right edge
                            if (col_sum >= tcw_pkg::COL_SUM_W'(tcw_pkg::COLUMNS))
                            begin
                                col_sum    = '0;
                                phase_next = '0;
                                row_inc    = 1'b1;
                            end
                            col_next = col_sum[tcw_pkg::COL_W-1:0];

                            if (row_inc && (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)))
                            begin
                                cnt_next   = '0;
                                state_next = tcw_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                if (row_inc)
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                                res_load = 1'b1;
                            end
                        end

                        tcw_pkg::CMD_READ:
                        begin
                            rd_ok_next = rd_in_range;
                            ram_re     = rd_in_range;
                            ram_raddr  = rd_addr;
                            state_next = tcw_pkg::ST_READ;
                        end

                        tcw_pkg::CMD_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            phase_next = '0;
                            cnt_next   = '0;
                            state_next = tcw_pkg::ST_FILL;
                        end

                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end

            tcw_pkg::ST_READ:
            begin
                res_load      = 1'b1;
                res_char_next = rd_ok_reg ? rdata_reg[7:0] : 8'h00;
                res_attr_next = rd_ok_reg ? rdata_reg[15:8] : 8'h00;
                state_next    = tcw_pkg::ST_IDLE;
            end

            tcw_pkg::ST_SCROLL:
            begin
                // read a cell one row down, write it back in the next cycle
                if (cp_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_dst_reg;
                    ram_wdata = rdata_reg;
                end
                if (cnt_reg != tcw_pkg::ADDR_W'(tcw_pkg::COPY_N))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                    cp_valid_next = 1'b1;
                    cp_dst_next   = cnt_reg;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
            end

            tcw_pkg::ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = blank_cell;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    cnt_next      = '0;
                    res_load      = 1'b1;
                    res_char_next = 8'h00;
                    res_attr_next = 8'h00;
                    state_next    = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase

        res_valid_next = res_load || (res_valid_reg && !res_move);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            cp_valid_reg  <= 1'b0;
            rd_ok_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            cp_valid_reg  <= cp_valid_next;
            rd_ok_reg     <= rd_ok_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_dst_reg   <= cp_dst_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_move)
        begin
            out_char_reg <= res_char_reg;
            out_attr_reg <= res_attr_reg;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;

    // no read and write of the same cell in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("cell store read and write collide");

    // cursor stays on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
        && (col_reg < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)))
        else $error("cursor off screen");

    // staging register is only loaded when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> !res_valid_reg)
        else $error("result staging overrun");

    // an accepted item blocks further items in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("item accepted while previous item in flight");

endmodule
